// ----- hw/rtl/sha_pkg.sv -----
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [63:0] digest_part0;
        logic [63:0] digest_part1;
        logic [63:0] digest_part2;
        logic [63:0] digest_part3;
    } res_t;

    // Queue entry between the byte packer and the compression engine.
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } job_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_RUN,
        ENG_ADD
    } eng_state_t;

    typedef enum logic [1:0] {
        FE_TAKE,
        FE_PAD2
    } fe_state_t;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CNT_W = 61;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha_packer.sv -----
`default_nettype none
module sha_packer
    import sha_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic take,
    input  req_t      req,
    input  wire logic q_full,
    output logic      push,
    output job_t      job,
    output logic      ready
);

    fe_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [511:0]       buf_reg, buf_next;

    function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] p,
                                         input logic [7:0] v);
        logic [511:0] r;
        r = b;
        r[(63 - p) * 8 +: 8] = v;
        return r;
    endfunction

    function automatic logic [511:0] pad_from(input logic [511:0] b, input logic [5:0] p);
        logic [511:0] r;
        logic [511:0] keep;
        keep = ~({512{1'b1}} >> (p * 8));
        r = (b & keep) | ({504'd0, PAD_BYTE} << ((63 - p) * 8));
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_TAKE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign ready = (state_reg == FE_TAKE) && !q_full;

    always_comb
    begin
        logic [CNT_W-1:0] c;
        logic [511:0]     b;
        logic [5:0]       p;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        buf_next   = buf_reg;
        push       = 1'b0;
        job        = '{block: buf_reg, final_blk: 1'b0};
        c = cnt_reg;
        b = buf_reg;
        p = '0;
        unique case (state_reg)
            FE_TAKE:
            begin
                if (take)
                begin
                    if (req.byte_valid && c != CNT_MAX)
                    begin
                        b = put(b, c[5:0], req.data_byte);
                        c = c + 1'b1;
                        if (c[5:0] == 6'd0 && !req.last_byte)
                        begin
                            push = 1'b1;
                            job  = '{block: b, final_blk: 1'b0};
                        end
                    end
                    if (req.last_byte)
                    begin
                        p = c[5:0];
                        if (c[5:0] == 6'd0 && req.byte_valid && c != cnt_reg)
                        begin
                            push = 1'b1;
                            job  = '{block: b, final_blk: 1'b0};
                            b = pad_from('0, 6'd0);
                            b[63:0] = {c, 3'b000};
                            state_next = FE_PAD2;
                        end
                        else
                        begin
                            b = pad_from(b, p);
                            if (p >= 6'd56)
                            begin
                                push = 1'b1;
                                job  = '{block: b, final_blk: 1'b0};
                                b = '0;
                                b[63:0] = {c, 3'b000};
                                state_next = FE_PAD2;
                            end
                            else
                            begin
                                b[63:0] = {c, 3'b000};
                                push = 1'b1;
                                job  = '{block: b, final_blk: 1'b1};
                            end
                        end
                        c = '0;
                    end
                    cnt_next = c;
                    buf_next = b;
                end
            end
            FE_PAD2:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    job        = '{block: buf_reg, final_blk: 1'b1};
                    state_next = FE_TAKE;
                end
            end
            default: state_next = FE_TAKE;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sha_queue.sv -----
`default_nettype none
module sha_queue
    import sha_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      wdata,
    input  wire logic pop,
    output job_t      rdata,
    output logic      empty,
    output logic      full,
    output logic      nearly_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t            mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     n_reg;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg  <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= inc(wp_reg);
            if (pop)
                rp_reg <= inc(rp_reg);
            n_reg <= n_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wdata;
    end

    assign rdata       = mem[rp_reg];
    assign empty       = (n_reg == '0);
    assign full        = (n_reg == (AW+1)'(DEPTH));
    assign nearly_full = (n_reg >= (AW+1)'(DEPTH - 1));

endmodule
`default_nettype wire

// ----- hw/rtl/sha_engine.sv -----
`default_nettype none
module sha_engine
    import sha_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  job_t      job,
    output logic      pop,
    output logic      done,
    output res_t      result
);

    eng_state_t     state_reg, state_next;
    logic [5:0]     rnd_reg, rnd_next;
    logic [255:0]   hv_reg, hv_next;
    logic [255:0]   wk_reg, wk_next;
    logic [511:0]   w_reg, w_next;
    logic           fin_reg, fin_next;
    res_t           res_reg, res_next;
    logic           done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            rnd_reg   <= '0;
            hv_reg    <= H_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            hv_reg    <= hv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wk_reg  <= wk_next;
        w_reg   <= w_next;
        fin_reg <= fin_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn, w0;
        logic [255:0] sum;
        state_next = state_reg;
        rnd_next   = rnd_reg;
        hv_next    = hv_reg;
        wk_next    = wk_reg;
        w_next     = w_reg;
        fin_next   = fin_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        {a, b, c, d, e, f, g, h} = wk_reg;
        w0 = w_reg[511:480];
        s0 = rotr(w_reg[479:448], 7) ^ rotr(w_reg[479:448], 18) ^ (w_reg[479:448] >> 3);
        s1 = rotr(w_reg[63:32], 17) ^ rotr(w_reg[63:32], 19) ^ (w_reg[63:32] >> 10);
        wn = w0 + s0 + w_reg[223:192] + s1;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(rnd_reg) + w0;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        for (int i = 0; i < 8; i++)
            sum[i*32 +: 32] = hv_reg[i*32 +: 32] + wk_reg[i*32 +: 32];
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    wk_next    = hv_reg;
                    w_next     = job.block;
                    fin_next   = job.final_blk;
                    rnd_next   = '0;
                    state_next = ENG_RUN;
                end
            end
            ENG_RUN:
            begin
                wk_next  = {t1 + t2, a, b, c, d + t1, e, f, g};
                w_next   = {w_reg[479:0], wn};
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == 6'd63)
                    state_next = ENG_ADD;
            end
            ENG_ADD:
            begin
                state_next = ENG_IDLE;
                if (fin_reg)
                begin
                    res_next  = '{sum[255:192], sum[191:128], sum[127:64], sum[63:0]};
                    done_next = 1'b1;
                    hv_next   = H_INIT;
                end
                else
                    hv_next = sum;
            end
            default: state_next = ENG_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sha256_message_hasher.sv -----
`default_nettype none
// SHA-256 message hasher.
// Request channel: start/busy with a packed request (data_byte, byte_valid,
// last_byte). A request is taken at a clock edge with start high and busy
// low. One request carries at most one message byte; last_byte closes the
// message, after which padding and the length are appended here.
// Result channel: result_valid strobes for one cycle with the 256-bit digest
// as four 64-bit big-endian words. The receiver cannot stall it.
// Throughput: bytes are taken one per cycle into the block buffer while busy
// is low; each full block is handed through a two-entry queue to the
// compression engine, which spends one load, one round per cycle and one
// chaining add on each block.
// The time from the closing request to the digest strobe depends on one or
// two final padding blocks and a block still running in the engine.
// busy rises while a block waits in the queue or a second padding block
// is pending.
// Reset clears the chaining value to the standard initial hash, the byte
// count and both state machines; no result is pending after reset.
module sha256_message_hasher
    import sha_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  req_t      request,
    output logic      result_valid,
    output res_t      result
);

    logic pk_ready, push, pop, q_empty, q_full, q_nf;
    job_t push_job, head_job;

    sha_packer u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (start && !busy),
        .req   (request),
        .q_full(q_nf),
        .push  (push),
        .job   (push_job),
        .ready (pk_ready)
    );

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wdata      (push_job),
        .pop        (pop),
        .rdata      (head_job),
        .empty      (q_empty),
        .full       (q_full),
        .nearly_full(q_nf)
    );

    sha_engine u_eng (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .job    (head_job),
        .pop    (pop),
        .done   (result_valid),
        .result (result)
    );

    assign busy = !pk_ready;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push) else $error("block queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !pop) else $error("block queue underflow");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("digest strobe too long");

endmodule
`default_nettype wire
